[hdl/luhn_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// luhn_pkg
// Shared constants and controller/datapath interface types for the Luhn check.
// ----------------------------------------------------------------------------
package luhn_pkg;

    localparam int CARD_W         = 64;
    localparam int BCD_DIGITS     = 20;  // a 64-bit value has at most 20 decimal digits
    localparam int CNT_W          = 5;
    localparam int OUT_W          = 8;
    localparam int MAX_DIGITS_DEF = 19;

    // binary to BCD conversion moves four bits per step
    localparam int CONV_BITS      = 4;
    localparam int CONV_STEPS     = CARD_W / CONV_BITS;
    localparam int CONV_CNT_W     = $clog2(CONV_STEPS);

    localparam logic [1:0] KIND_INVALID = 2'd0;
    localparam logic [1:0] KIND_LEAD4   = 2'd1;
    localparam logic [1:0] KIND_LEAD3X  = 2'd2;
    localparam logic [1:0] KIND_LEAD5X  = 2'd3;

    typedef struct packed {
        logic load;
        logic conv_step;
        logic scan_step;
        logic out_load;
    } luhn_cmd_t;

    typedef struct packed {
        logic scan_stop;
    } luhn_status_t;

endpackage

[hdl/luhn_card_number_check_unit.sv]
`timescale 1ns / 1ps
// Flow: a word is accepted in idle, converted from binary to BCD (four bits per cycle),
// then scanned one digit per step (N = digit count, 0..19) and loaded into the output
// register once any earlier word there has been taken; the next input waits till then.
// A finished word waits in the output register while the next input is taken.
// Reset: rst_n asynchronous, active low; clears the controller and output valid.
// ----------------------------------------------------------------------------
// luhn_card_number_check_unit
// Luhn mod-10 card number check with issuer classification by leading digits.
// ----------------------------------------------------------------------------
module luhn_card_number_check_unit #(
    parameter int MAX_DIGITS = luhn_pkg::MAX_DIGITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [luhn_pkg::CARD_W-1:0] s_axis_tdata,   // [63:0] card_number
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [luhn_pkg::OUT_W-1:0]  m_axis_tdata    // [1:0] issuer_kind, [2] checksum_ok,
                                                        // [7:3] digit_count
);

    luhn_pkg::luhn_cmd_t    cmd;
    luhn_pkg::luhn_status_t status;

    luhn_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .status        (status),
        .cmd           (cmd)
    );

    luhn_dp #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dp (
        .clk         (clk),
        .cmd         (cmd),
        .card_number (s_axis_tdata),
        .status      (status),
        .out_data    (m_axis_tdata)
    );

endmodule

[hdl/luhn_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// luhn_dp
// Datapath: binary to BCD conversion, digit scan with running Luhn sum mod 10,
// classification and output word register.
// ----------------------------------------------------------------------------
module luhn_dp #(
    parameter int MAX_DIGITS = luhn_pkg::MAX_DIGITS_DEF
) (
    input  logic                           clk,
    input  luhn_pkg::luhn_cmd_t            cmd,
    input  logic [luhn_pkg::CARD_W-1:0]    card_number,
    output luhn_pkg::luhn_status_t         status,
    output logic [luhn_pkg::OUT_W-1:0]     out_data
);

    localparam int BCD_W = luhn_pkg::BCD_DIGITS * 4;
    localparam int CW    = luhn_pkg::CNT_W;

    logic [luhn_pkg::CARD_W-1:0] bin_reg;
    logic [BCD_W-1:0]            bcd_reg;
    logic [CW-1:0]               cnt_reg;
    logic [3:0]                  sum_reg;
    logic [3:0]                  lead_reg;
    logic [3:0]                  second_reg;
    logic [luhn_pkg::OUT_W-1:0]  out_reg;

    logic [luhn_pkg::CARD_W-1:0] bin_next;
    logic [BCD_W-1:0]            bcd_next;

    logic [3:0] digit;
    logic [4:0] dbl;
    logic [4:0] dbl_adj;
    logic [3:0] addend;
    logic [4:0] sum_raw;
    logic [3:0] sum_next;

    logic       overflow;
    logic       sum_ok;
    logic [1:0] kind;
    logic [luhn_pkg::OUT_W-1:0] out_next;

    // double dabble, four shifts per cycle
    always_comb
    begin
        bin_next = bin_reg;
        bcd_next = bcd_reg;
        for (int s = 0; s < luhn_pkg::CONV_BITS; s++)
        begin
            for (int k = 0; k < luhn_pkg::BCD_DIGITS; k++)
            begin
                if (bcd_next[4*k +: 4] >= 4'd5)
                begin
                    bcd_next[4*k +: 4] = bcd_next[4*k +: 4] + 4'd3;
                end
            end
            bcd_next = {bcd_next[BCD_W-2:0], bin_next[luhn_pkg::CARD_W-1]};
            bin_next = {bin_next[luhn_pkg::CARD_W-2:0], 1'b0};
        end
    end

    // one digit per scan step, least significant first
    always_comb
    begin
        digit   = bcd_reg[3:0];
        dbl     = {digit, 1'b0};
        dbl_adj = (dbl >= 5'd10) ? (dbl - 5'd9) : dbl;
        addend  = cnt_reg[0] ? dbl_adj[3:0] : digit;
        sum_raw = {1'b0, sum_reg} + {1'b0, addend};
        sum_next = (sum_raw >= 5'd10) ? 4'(sum_raw - 5'd10) : sum_raw[3:0];
    end

    assign status.scan_stop = (bcd_reg == '0) || (cnt_reg == CW'(MAX_DIGITS));

    always_comb
    begin
        overflow = (bcd_reg != '0);
        sum_ok   = (sum_reg == 4'd0);
        kind     = luhn_pkg::KIND_INVALID;
        if (sum_ok && (cnt_reg >= CW'(2)))
        begin
            if ((lead_reg == 4'd4) && ((cnt_reg == CW'(13)) || (cnt_reg == CW'(16))))
            begin
                kind = luhn_pkg::KIND_LEAD4;
            end
            else if ((lead_reg == 4'd3) && ((second_reg == 4'd4) || (second_reg == 4'd7))
                     && (cnt_reg == CW'(15)))
            begin
                kind = luhn_pkg::KIND_LEAD3X;
            end
            else if ((lead_reg == 4'd5) && (second_reg >= 4'd1) && (second_reg <= 4'd5)
                     && (cnt_reg == CW'(16)))
            begin
                kind = luhn_pkg::KIND_LEAD5X;
            end
        end
        out_next = overflow ? '0 : {cnt_reg, sum_ok, kind};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            bin_reg    <= card_number;
            bcd_reg    <= '0;
            cnt_reg    <= '0;
            sum_reg    <= '0;
            lead_reg   <= '0;
            second_reg <= '0;
        end
        else if (cmd.conv_step)
        begin
            bin_reg <= bin_next;
            bcd_reg <= bcd_next;
        end
        else if (cmd.scan_step)
        begin
            bcd_reg    <= {4'd0, bcd_reg[BCD_W-1:4]};
            cnt_reg    <= cnt_reg + CW'(1);
            sum_reg    <= sum_next;
            second_reg <= lead_reg;
            lead_reg   <= digit;
        end
        if (cmd.out_load)
        begin
            out_reg <= out_next;
        end
    end

    assign out_data = out_reg;

`ifndef SYNTHESIS
    a_sum_range: assert property (@(posedge clk) cmd.scan_step |=> (sum_reg < 4'd10))
        else $error("running digit sum left mod-10 range");
    a_cnt_limit: assert property (@(posedge clk)
        cmd.scan_step |-> (cnt_reg < CW'(MAX_DIGITS)))
        else $error("digit scan ran past the digit limit");
    a_cnt_clear: assert property (@(posedge clk) cmd.load |=> (cnt_reg == '0))
        else $error("digit count not cleared on new word");
`endif

endmodule

[hdl/luhn_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// luhn_ctrl
// Controller: sequences conversion, digit scan and output handoff; owns the
// stream handshakes and the output valid flag.
// ----------------------------------------------------------------------------
module luhn_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    input  luhn_pkg::luhn_status_t  status,
    output luhn_pkg::luhn_cmd_t     cmd
);

    localparam int CCW = luhn_pkg::CONV_CNT_W;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CONV = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t         state_reg, state_next;
    logic [CCW-1:0] conv_cnt_reg, conv_cnt_next;
    logic           out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        conv_cnt_next  = conv_cnt_reg;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                conv_cnt_next = '0;
                if (s_axis_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                cmd.conv_step = 1'b1;
                conv_cnt_next = conv_cnt_reg + CCW'(1);
                if (conv_cnt_reg == CCW'(luhn_pkg::CONV_STEPS - 1))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.scan_stop)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            conv_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            conv_cnt_reg  <= conv_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || m_axis_tready))
        else $error("pending output word overwritten");
    a_accept_conv: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (state_reg == ST_CONV) && (conv_cnt_reg == '0))
        else $error("accepted word did not start conversion");
    a_conv_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CONV) && (conv_cnt_reg == CCW'(luhn_pkg::CONV_STEPS - 1))
        |=> (state_reg == ST_SCAN))
        else $error("conversion length wrong");
`endif

endmodule
